[rtl/core/kls_pkg.sv]
// Shared constants and codes for the keymap layer stack resolver.
// No dependencies; the resolver module imports this package.
package kls_pkg;

    localparam int NUM_LAYERS_DEF = 8;
    localparam int NUM_KEYS_DEF   = 256;

    // function codes
    localparam logic [2:0] FN_TOGGLE = 3'd0;
    localparam logic [2:0] FN_LATCH  = 3'd1;
    localparam logic [2:0] FN_LOCK   = 3'd2;
    localparam logic [2:0] FN_SHIFT  = 3'd3;
    localparam logic [2:0] FN_ROTATE = 3'd4;
    localparam logic [2:0] FN_LOOKUP = 3'd5;
    localparam logic [2:0] FN_CLEAR  = 3'd6;
    localparam logic [2:0] FN_DEFINE = 3'd7;

    // key phases
    localparam logic [1:0] PH_PRESS   = 2'd0;
    localparam logic [1:0] PH_HOLD    = 2'd1;
    localparam logic [1:0] PH_RELEASE = 2'd2;
    localparam logic [1:0] PH_OTHER   = 2'd3;

    // layer state bits
    localparam logic [2:0] ST_SHIFT = 3'b001;
    localparam logic [2:0] ST_LATCH = 3'b010;
    localparam logic [2:0] ST_LOCK  = 3'b100;

    // transitions
    localparam logic [1:0] TR_NONE   = 2'd0;
    localparam logic [1:0] TR_STILL  = 2'd1;
    localparam logic [1:0] TR_ACT    = 2'd2;
    localparam logic [1:0] TR_DEACT  = 2'd3;

    // result kinds
    localparam logic KIND_EVENT  = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

endpackage

[rtl/core/kls_if.sv]
// Item channels of the keymap layer stack resolver: request and response.
// Depends on nothing; fields match the block's item formats.
interface kls_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [1:0] phase;
    logic [2:0] layer;
    logic [2:0] state_bits;
    logic       direction;
    logic [7:0] key;
    logic       latch_clear;
    logic       defined;

    modport source (output valid, func, phase, layer, state_bits, direction, key,
                    latch_clear, defined, input ready);
    modport sink   (input valid, func, phase, layer, state_bits, direction, key,
                    latch_clear, defined, output ready);
endinterface

interface kls_rsp_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [2:0] out_layer;
    logic [1:0] transition;
    logic       hit;
    logic       last;

    modport source (output valid, kind, out_layer, transition, hit, last, input ready);
    modport sink   (input valid, kind, out_layer, transition, hit, last, output ready);
endinterface

[rtl/core/kls_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kls_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/core/keymap_layer_stack_resolver.sv]
// Keymap layer stack resolver: layer state bits, activation stack, cached lookups.
// Sequencing: a layer change searches the stack and, when a layer drops out, compacts
// it, one entry a cycle; a press lookup walks the stack from the top, each step
// reading the key map, with a possible latch expiry on the way; every result may
// wait while the previous result is still held.
// Throughput: one item at a time; the next item is taken once the sequencer is idle.
// Reset: control state clears at once, then a clearing pass over all NUM_LAYERS*NUM_KEYS
// key map entries zeroes the key map and the cache while no item is taken.
module keymap_layer_stack_resolver #(
    parameter int NUM_LAYERS = kls_pkg::NUM_LAYERS_DEF,
    parameter int NUM_KEYS   = kls_pkg::NUM_KEYS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    kls_req_if.sink    req,
    kls_rsp_if.source  rsp
);
    import kls_pkg::*;

    localparam int LW    = $clog2(NUM_LAYERS);
    localparam int CW    = $clog2(NUM_LAYERS + 1);
    localparam int KW    = $clog2(NUM_KEYS);
    localparam int DEPTH = NUM_LAYERS * NUM_KEYS;
    localparam int PAW   = $clog2(DEPTH);

    // sequencer states
    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_EXEC   = 5'd2;
    localparam logic [4:0] LS_SRCH  = 5'd3;
    localparam logic [4:0] LS_APPLY = 5'd4;
    localparam logic [4:0] LS_SHIFT = 5'd5;
    localparam logic [4:0] LS_EMIT  = 5'd6;
    localparam logic [4:0] S_ROT2   = 5'd7;
    localparam logic [4:0] S_HR_C   = 5'd8;
    localparam logic [4:0] S_HR_X   = 5'd9;
    localparam logic [4:0] S_HR_P   = 5'd10;
    localparam logic [4:0] S_HR_Q   = 5'd11;
    localparam logic [4:0] S_W_TOP  = 5'd12;
    localparam logic [4:0] S_W_CHK  = 5'd13;
    localparam logic [4:0] S_W_DEC  = 5'd14;
    localparam logic [4:0] S_BASE   = 5'd15;
    localparam logic [4:0] S_BASE2  = 5'd16;
    localparam logic [4:0] S_ANS    = 5'd17;

    logic [4:0]     state_reg, state_next;
    logic [4:0]     ret_reg, ret_next;
    logic [PAW-1:0] clr_reg, clr_next;

    // captured item
    logic [2:0] func_reg, func_next;
    logic [1:0] phase_reg, phase_next;
    logic [2:0] layer_reg, layer_next;
    logic [2:0] mask_reg, mask_next;
    logic       dir_reg, dir_next;
    logic [7:0] key_reg, key_next;
    logic       exp_reg, exp_next;
    logic       def_reg, def_next;

    // layer state and stack
    logic [2:0]    bits_reg  [NUM_LAYERS];
    logic [2:0]    bits_next [NUM_LAYERS];
    logic [LW-1:0] stack_reg  [NUM_LAYERS];
    logic [LW-1:0] stack_next [NUM_LAYERS];
    logic [CW-1:0] count_reg, count_next;
    logic [LW-1:0] rot_reg, rot_next;

    // layer-set subroutine
    logic [LW-1:0] ls_lay_reg, ls_lay_next;
    logic [2:0]    ls_mask_reg, ls_mask_next;
    logic          ls_last_reg, ls_last_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          found_reg, found_next;
    logic [1:0]    trans_reg, trans_next;

    // lookup
    logic [LW-1:0] look_reg, look_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          par_reg, par_next;
    logic          xl_reg, xl_next;
    logic          hit_reg, hit_next;

    // response register
    logic       ov_reg, ov_next;
    logic       okind_reg, okind_next;
    logic [2:0] olay_reg, olay_next;
    logic [1:0] otr_reg, otr_next;
    logic       ohit_reg, ohit_next;
    logic       olast_reg, olast_next;

    // memories
    logic           kp_we, kp_wdata, kp_rdata;
    logic [PAW-1:0] kp_waddr, kp_raddr;
    logic           rc_we;
    logic [KW-1:0]  rc_waddr, rc_raddr;
    logic [LW-1:0]  rc_wdata, rc_rdata;

    kls_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_key_map (
        .clk   (clk),
        .we    (kp_we),
        .waddr (kp_waddr),
        .wdata (kp_wdata),
        .raddr (kp_raddr),
        .rdata (kp_rdata)
    );

    kls_ram #(.WIDTH(LW), .DEPTH(NUM_KEYS)) u_cache (
        .clk   (clk),
        .we    (rc_we),
        .waddr (rc_waddr),
        .wdata (rc_wdata),
        .raddr (rc_raddr),
        .rdata (rc_rdata)
    );

    logic          lay_ok, key_ok, emit_ok;
    logic [LW-1:0] lay_idx, nrot;
    logic [KW-1:0] kidx;

    assign lay_ok  = (32'(layer_reg) < NUM_LAYERS);
    assign key_ok  = (32'(key_reg) < NUM_KEYS);
    assign lay_idx = LW'(layer_reg);
    assign kidx    = KW'(key_reg);
    assign emit_ok = !ov_reg || rsp.ready;

    // next rotation target, wrapping within the layer count
    always_comb
    begin
        if (!dir_reg)
        begin
            nrot = (rot_reg == LW'(NUM_LAYERS - 1)) ? '0 : rot_reg + LW'(1);
        end
        else
        begin
            nrot = (rot_reg == '0) ? LW'(NUM_LAYERS - 1) : rot_reg - LW'(1);
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = ov_reg;
    assign rsp.kind       = okind_reg;
    assign rsp.out_layer  = olay_reg;
    assign rsp.transition = otr_reg;
    assign rsp.hit        = ohit_reg;
    assign rsp.last       = olast_reg;

    always_comb
    begin
        logic [2:0]    oldv;
        logic [2:0]    newv;
        logic [2:0]    b;
        logic [1:0]    tr;
        logic [CW-1:0] pn;
        logic [CW-1:0] im;
        logic [LW-1:0] wl;

        oldv = '0;
        newv = '0;
        b    = '0;
        tr   = TR_NONE;
        pn   = '0;
        im   = '0;
        wl   = '0;

        state_next   = state_reg;
        ret_next     = ret_reg;
        clr_next     = clr_reg;
        func_next    = func_reg;
        phase_next   = phase_reg;
        layer_next   = layer_reg;
        mask_next    = mask_reg;
        dir_next     = dir_reg;
        key_next     = key_reg;
        exp_next     = exp_reg;
        def_next     = def_reg;
        bits_next    = bits_reg;
        stack_next   = stack_reg;
        count_next   = count_reg;
        rot_next     = rot_reg;
        ls_lay_next  = ls_lay_reg;
        ls_mask_next = ls_mask_reg;
        ls_last_next = ls_last_reg;
        pos_next     = pos_reg;
        found_next   = found_reg;
        trans_next   = trans_reg;
        look_next    = look_reg;
        idx_next     = idx_reg;
        par_next     = par_reg;
        xl_next      = xl_reg;
        hit_next     = hit_reg;

        ov_next    = ov_reg && !rsp.ready;
        okind_next = okind_reg;
        olay_next  = olay_reg;
        otr_next   = otr_reg;
        ohit_next  = ohit_reg;
        olast_next = olast_reg;

        kp_we    = 1'b0;
        kp_waddr = PAW'(lay_idx) * PAW'(NUM_KEYS) + PAW'(kidx);
        kp_wdata = def_reg;
        kp_raddr = PAW'(look_reg) * PAW'(NUM_KEYS) + PAW'(kidx);
        rc_we    = 1'b0;
        rc_waddr = kidx;
        rc_wdata = look_reg;
        rc_raddr = kidx;

        case (state_reg)
            S_CLR:
            begin
                // zero key map and cache, one entry a cycle
                kp_we    = 1'b1;
                kp_waddr = clr_reg;
                kp_wdata = 1'b0;
                rc_we    = (clr_reg < PAW'(NUM_KEYS));
                rc_waddr = KW'(clr_reg);
                rc_wdata = '0;
                clr_next = clr_reg + PAW'(1);
                if (clr_reg == PAW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next  = req.func;
                    phase_next = req.phase;
                    layer_next = req.layer;
                    mask_next  = req.state_bits;
                    dir_next   = req.direction;
                    key_next   = req.key;
                    exp_next   = req.latch_clear;
                    def_next   = req.defined;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next   = S_IDLE;
                ret_next     = S_IDLE;
                ls_lay_next  = lay_idx;
                ls_last_next = 1'b1;
                pos_next     = '0;
                case (func_reg)
                    FN_TOGGLE:
                    begin
                        ls_mask_next = mask_reg;
                        if (lay_ok && (phase_reg == PH_PRESS || phase_reg == PH_RELEASE))
                        begin
                            state_next = LS_SRCH;
                        end
                    end
                    FN_LATCH:
                    begin
                        ls_mask_next = ST_LATCH;
                        if (lay_ok && phase_reg == PH_RELEASE)
                        begin
                            state_next = LS_SRCH;
                        end
                    end
                    FN_LOCK:
                    begin
                        ls_mask_next = ST_LOCK;
                        if (lay_ok && phase_reg == PH_PRESS)
                        begin
                            state_next = LS_SRCH;
                        end
                    end
                    FN_SHIFT:
                    begin
                        ls_mask_next = ST_SHIFT;
                        if (lay_ok)
                        begin
                            if ((phase_reg == PH_PRESS && bits_reg[lay_idx] == '0)
                                || (phase_reg == PH_RELEASE && bits_reg[lay_idx] != '0))
                            begin
                                state_next = LS_SRCH;
                            end
                        end
                    end
                    FN_ROTATE:
                    begin
                        // unlock the old rotation target, then lock the new one
                        if (phase_reg == PH_PRESS)
                        begin
                            ls_lay_next  = rot_reg;
                            ls_mask_next = ST_LOCK;
                            ls_last_next = (nrot == '0);
                            ret_next     = S_ROT2;
                            state_next   = (rot_reg != '0) ? LS_SRCH : S_ROT2;
                        end
                    end
                    FN_LOOKUP:
                    begin
                        if (phase_reg == PH_HOLD || phase_reg == PH_RELEASE)
                        begin
                            state_next = S_HR_C;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = S_W_TOP;
                        end
                    end
                    FN_CLEAR:
                    begin
                        count_next = '0;
                        for (int i = 0; i < NUM_LAYERS; i++)
                        begin
                            bits_next[i] = '0;
                        end
                    end
                    default:
                    begin
                        kp_we = lay_ok && key_ok;
                    end
                endcase
            end

            LS_SRCH:
            begin
                // find the layer on the stack, one entry a cycle
                if (ls_lay_reg == '0)
                begin
                    state_next = ret_reg;
                end
                else if (pos_reg < count_reg)
                begin
                    if (stack_reg[pos_reg[LW-1:0]] == ls_lay_reg)
                    begin
                        found_next = 1'b1;
                        state_next = LS_APPLY;
                    end
                    else
                    begin
                        pos_next = pos_reg + CW'(1);
                    end
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = LS_APPLY;
                end
            end

            LS_APPLY:
            begin
                oldv = bits_reg[ls_lay_reg];
                if ((oldv & ls_mask_reg) != '0)
                begin
                    newv = oldv & ~ls_mask_reg;
                end
                else
                begin
                    newv = oldv | ls_mask_reg;
                end
                bits_next[ls_lay_reg] = newv;
                if (oldv != '0 && newv != '0)
                begin
                    tr = TR_STILL;
                end
                else if (oldv == '0 && newv != '0)
                begin
                    tr = TR_ACT;
                end
                else if (oldv != '0 && newv == '0)
                begin
                    tr = TR_DEACT;
                end
                else
                begin
                    tr = TR_NONE;
                end
                trans_next = tr;
                if (!found_reg && count_reg < CW'(NUM_LAYERS))
                begin
                    stack_next[count_reg[LW-1:0]] = ls_lay_reg;
                    count_next = count_reg + CW'(1);
                end
                if (found_reg && newv == '0)
                begin
                    state_next = LS_SHIFT;
                end
                else
                begin
                    state_next = (tr != TR_NONE) ? LS_EMIT : ret_reg;
                end
            end

            LS_SHIFT:
            begin
                // close the gap left by the removed layer
                pn = pos_reg + CW'(1);
                if (pn < count_reg)
                begin
                    stack_next[pos_reg[LW-1:0]] = stack_reg[pn[LW-1:0]];
                    pos_next = pn;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = (trans_reg != TR_NONE) ? LS_EMIT : ret_reg;
                end
            end

            LS_EMIT:
            begin
                if (emit_ok)
                begin
                    ov_next    = 1'b1;
                    okind_next = KIND_EVENT;
                    olay_next  = 3'(ls_lay_reg);
                    otr_next   = trans_reg;
                    ohit_next  = 1'b0;
                    olast_next = ls_last_reg;
                    state_next = ret_reg;
                end
            end

            S_ROT2:
            begin
                rot_next     = nrot;
                ls_lay_next  = nrot;
                ls_mask_next = ST_LOCK;
                ls_last_next = 1'b1;
                pos_next     = '0;
                ret_next     = S_IDLE;
                state_next   = LS_SRCH;
            end

            S_HR_C:
            begin
                look_next  = key_ok ? rc_rdata : '0;
                state_next = S_HR_X;
            end

            S_HR_X:
            begin
                ls_lay_next  = look_reg;
                ls_mask_next = ST_LATCH;
                ls_last_next = 1'b0;
                pos_next     = '0;
                ret_next     = S_HR_P;
                if (exp_reg && (bits_reg[look_reg] & ST_LATCH) != '0)
                begin
                    state_next = LS_SRCH;
                end
                else
                begin
                    state_next = S_HR_P;
                end
            end

            S_HR_P:
            begin
                state_next = S_HR_Q;
            end

            S_HR_Q:
            begin
                hit_next   = kp_rdata && key_ok;
                state_next = S_ANS;
            end

            S_W_TOP:
            begin
                // visit the next stack entry from the top
                if (idx_reg == '0)
                begin
                    look_next  = '0;
                    state_next = S_BASE;
                end
                else
                begin
                    im         = idx_reg - CW'(1);
                    wl         = stack_reg[im[LW-1:0]];
                    b          = bits_reg[wl];
                    look_next  = wl;
                    par_next   = ^b;
                    xl_next    = b[1];
                    kp_raddr   = PAW'(wl) * PAW'(NUM_KEYS) + PAW'(kidx);
                    state_next = S_W_CHK;
                end
            end

            S_W_CHK:
            begin
                hit_next     = kp_rdata && key_ok;
                ls_lay_next  = look_reg;
                ls_mask_next = ST_LATCH;
                ls_last_next = 1'b0;
                pos_next     = '0;
                ret_next     = S_W_DEC;
                state_next   = (xl_reg && exp_reg) ? LS_SRCH : S_W_DEC;
            end

            S_W_DEC:
            begin
                if (par_reg && hit_reg)
                begin
                    rc_we      = 1'b1;
                    state_next = S_ANS;
                end
                else
                begin
                    idx_next   = idx_reg - CW'(1);
                    state_next = S_W_TOP;
                end
            end

            S_BASE:
            begin
                state_next = S_BASE2;
            end

            S_BASE2:
            begin
                // fall back to the base layer
                hit_next   = kp_rdata && key_ok;
                rc_we      = kp_rdata && key_ok;
                state_next = S_ANS;
            end

            S_ANS:
            begin
                if (emit_ok)
                begin
                    ov_next    = 1'b1;
                    okind_next = KIND_ANSWER;
                    olay_next  = 3'(look_reg);
                    otr_next   = TR_NONE;
                    ohit_next  = hit_reg;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            count_reg <= '0;
            rot_reg   <= '0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < NUM_LAYERS; i++)
            begin
                bits_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            rot_reg   <= rot_next;
            ov_reg    <= ov_next;
            bits_reg  <= bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg     <= ret_next;
        func_reg    <= func_next;
        phase_reg   <= phase_next;
        layer_reg   <= layer_next;
        mask_reg    <= mask_next;
        dir_reg     <= dir_next;
        key_reg     <= key_next;
        exp_reg     <= exp_next;
        def_reg     <= def_next;
        stack_reg   <= stack_next;
        ls_lay_reg  <= ls_lay_next;
        ls_mask_reg <= ls_mask_next;
        ls_last_reg <= ls_last_next;
        pos_reg     <= pos_next;
        found_reg   <= found_next;
        trans_reg   <= trans_next;
        look_reg    <= look_next;
        idx_reg     <= idx_next;
        par_reg     <= par_next;
        xl_reg      <= xl_next;
        hit_reg     <= hit_next;
        okind_reg   <= okind_next;
        olay_reg    <= olay_next;
        otr_reg     <= otr_next;
        ohit_reg    <= ohit_next;
        olast_reg   <= olast_next;
    end

endmodule
